### rtl/ggdt_pkg.sv
// Shared types, constants and helpers for the generation-guarded deadline timers.
// Used by ggdt_ctrl, ggdt_dp and generation_guarded_deadline_timers.
// No dependencies.
package ggdt_pkg;

    // Slot counts; both fit the 3-bit owner field (1..8 and 0..8)
    localparam int OWNER_SLOTS      = 5;
    localparam int GENERATION_SLOTS = 4;

    // Longest accepted schedule delay
    localparam logic [31:0] MAX_DELAY_MS = 32'h7fff_ffff;

    // Request type codes as carried on the input channel
    typedef enum logic [2:0] {
        REQ_SCHEDULE = 3'd0,
        REQ_CANCEL   = 3'd1,
        REQ_CLEAR    = 3'd2,
        REQ_NEXT     = 3'd3,
        REQ_TAKE_DUE = 3'd4
    } t_req;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_STALE    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    // Decoded operation of the latched request
    typedef enum logic [2:0] {
        OP_SCHED,
        OP_CANCEL,
        OP_CLEAR,
        OP_NEXT,
        OP_TAKE,
        OP_BAD
    } t_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCHED_GEN,
        S_SCHED_DUE,
        S_SINGLE,
        S_RESULT,
        S_DUE_APPLY,
        S_DUE_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_step;
        logic sched_gen;
        logic sched_due;
        logic single_op;
        logic due_apply;
        logic emit_single;
        logic emit_event;
        logic skip;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic scan_last;
        logic mask_empty;
        logic rest_hit;
        logic rest_last;
        logic out_free;
    } t_stat;

    // Owners below GENERATION_SLOTS keep a generation cursor
    function automatic logic has_cursor(input logic [2:0] owner);
        return {1'b0, owner} < 4'(GENERATION_SLOTS);
    endfunction

endpackage

### rtl/ggdt_ctrl.sv
// Sequencer for the deadline timers: walks each request through its steps.
// Depends on ggdt_pkg; drives ggdt_dp through t_cmd and reads t_stat.
module ggdt_ctrl
    import ggdt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_NEXT, OP_TAKE: n_state = S_SCAN;
                    OP_SCHED:         n_state = S_SCHED_GEN;
                    default:          n_state = S_SINGLE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = (i_stat.op == OP_TAKE) ? S_DUE_APPLY : S_RESULT;
                end
            end
            S_SCHED_GEN: n_state = S_SCHED_DUE;
            S_SCHED_DUE: n_state = S_RESULT;
            S_SINGLE:    n_state = S_RESULT;
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_DUE_APPLY: begin
                n_state = i_stat.mask_empty ? S_RESULT : S_DUE_EMIT;
            end
            S_DUE_EMIT: begin
                if (i_stat.rest_hit && i_stat.out_free && i_stat.rest_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DISPATCH:  ;
            S_SCAN:      o_cmd.scan_step = 1'b1;
            S_SCHED_GEN: o_cmd.sched_gen = 1'b1;
            S_SCHED_DUE: o_cmd.sched_due = 1'b1;
            S_SINGLE:    o_cmd.single_op = 1'b1;
            S_RESULT:    o_cmd.emit_single = i_stat.out_free;
            S_DUE_APPLY: o_cmd.due_apply = 1'b1;
            S_DUE_EMIT: begin
                o_cmd.emit_event = i_stat.rest_hit && i_stat.out_free;
                o_cmd.skip       = !i_stat.rest_hit;
            end
            default: ;
        endcase
    end

    // A result is loaded only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_single || o_cmd.emit_event) |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

    // Take-due with an empty mask reports exactly one single result
    a_empty_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUE_APPLY && i_stat.mask_empty) |=> r_state == S_RESULT)
        else $error("empty take-due did not go to single result");

    // Every event step either emits, skips or waits for the output
    a_emit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUE_EMIT && !i_stat.rest_hit) |=> r_state == S_DUE_EMIT)
        else $error("event emission left early");

endmodule

### rtl/ggdt_dp.sv
// Datapath of the deadline timers: timer state, slot scan and output register.
// Depends on ggdt_pkg; commanded by ggdt_ctrl.
module ggdt_dp
    import ggdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_req_type,
    input  logic [2:0]  i_owner,
    input  logic [63:0] i_generation,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_delay_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_next_delay_ms,
    output logic [7:0]  o_expired_mask,
    output logic        o_event_valid,
    output logic [2:0]  o_event_owner,
    output logic [63:0] o_event_generation,
    output logic        o_last
);

    // Latched request
    t_op         r_op;
    logic [2:0]  r_idx;
    logic [63:0] r_gen;
    logic [31:0] r_now;
    logic [31:0] r_delay;

    // Per-request working registers
    t_status     r_stat;
    logic        r_stop;
    logic        r_found;
    logic [31:0] r_best;
    logic [7:0]  r_mask;
    logic [7:0]  r_rest;

    // Timer state
    logic [7:0]  r_pending;
    logic [31:0] r_due    [8];
    logic [63:0] r_cursor [8];

    // Output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic        r_out_found;
    logic [31:0] r_out_next;
    logic [7:0]  r_out_mask;
    logic        r_out_ev;
    logic [2:0]  r_out_owner;
    logic [63:0] r_out_gen;
    logic        r_out_last;

    logic        owner_ok;
    t_op         load_op;
    logic        hc;
    logic [63:0] cur_sel;
    logic [31:0] due_sel;
    logic        pend_sel;
    logic [31:0] diff;
    logic        is_due_sel;
    logic [31:0] rem;
    logic [7:0]  idx_bit;
    logic        out_free;
    t_status     single_status;

    // Request decode at acceptance
    always_comb begin
        owner_ok = {1'b0, i_owner} < 4'(OWNER_SLOTS);
        load_op  = OP_BAD;
        priority if (i_req_type == REQ_NEXT)                  load_op = OP_NEXT;
        else if (i_req_type == REQ_TAKE_DUE)                  load_op = OP_TAKE;
        else if (i_req_type == REQ_SCHEDULE && owner_ok)      load_op = OP_SCHED;
        else if (i_req_type == REQ_CANCEL && owner_ok)        load_op = OP_CANCEL;
        else if (i_req_type == REQ_CLEAR && owner_ok)         load_op = OP_CLEAR;
        else                                                  load_op = OP_BAD;
    end

    // Slot read at the current index; remaining delay is zero once due
    always_comb begin
        hc         = has_cursor(r_idx);
        cur_sel    = hc ? r_cursor[r_idx] : '0;
        due_sel    = r_due[r_idx];
        pend_sel   = r_pending[r_idx];
        diff       = r_now - due_sel;
        is_due_sel = !diff[31];
        rem        = is_due_sel ? '0 : (due_sel - r_now);
        idx_bit    = 8'(1) << r_idx;
        out_free   = !r_out_valid || i_ready;
    end

    // Status of a single-result request
    always_comb begin
        unique case (r_op)
            OP_NEXT: single_status = r_found ? ST_OK : ST_NONE;
            OP_TAKE: single_status = ST_NONE;
            default: single_status = r_stat;
        endcase
    end

    // Request and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= load_op;
            r_idx   <= (load_op == OP_NEXT || load_op == OP_TAKE) ? 3'd0 : i_owner;
            r_gen   <= i_generation;
            r_now   <= i_now_ms;
            r_delay <= i_delay_ms;
            r_found <= 1'b0;
            r_best  <= '0;
            r_mask  <= '0;
            r_stop  <= 1'b0;
            r_stat  <= ST_INVALID;
        end else if (i_cmd.scan_step) begin
            if (r_op == OP_NEXT) begin
                if (pend_sel && (!r_found || rem < r_best)) begin
                    r_best  <= rem;
                    r_found <= 1'b1;
                end
            end else if (pend_sel && is_due_sel) begin
                r_mask <= r_mask | idx_bit;
            end
            r_idx <= r_idx + 3'd1;
        end else if (i_cmd.sched_gen) begin
            // Generation and delay checks
            if (r_delay > MAX_DELAY_MS) begin
                r_stat <= ST_INVALID;
                r_stop <= 1'b1;
            end else if (!hc && r_gen != '0) begin
                r_stat <= ST_INVALID;
                r_stop <= 1'b1;
            end else if (hc && (r_gen == '0 || r_gen < cur_sel)) begin
                r_stat <= ST_STALE;
                r_stop <= 1'b1;
            end else begin
                r_stat <= ST_OK;
                r_stop <= 1'b0;
            end
        end else if (i_cmd.sched_due) begin
            if (!r_stop && !(pend_sel && rem <= r_delay)) begin
                r_due[r_idx] <= r_now + r_delay;
            end
        end else if (i_cmd.single_op) begin
            unique case (r_op)
                OP_CANCEL: r_stat <= (r_gen != cur_sel) ? ST_MISMATCH : ST_OK;
                OP_CLEAR:  r_stat <= ST_OK;
                default:   r_stat <= ST_INVALID;
            endcase
        end else if (i_cmd.due_apply) begin
            r_rest <= r_mask;
            r_idx  <= '0;
        end else if (i_cmd.emit_event) begin
            r_rest <= r_rest & ~idx_bit;
            r_idx  <= r_idx + 3'd1;
        end else if (i_cmd.skip) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Pending bits and generation cursors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            for (int k = 0; k < 8; k++) begin
                r_cursor[k] <= '0;
            end
        end else if (i_cmd.sched_gen) begin
            if (r_delay <= MAX_DELAY_MS && hc && r_gen != '0 && r_gen >= cur_sel) begin
                if (r_gen > cur_sel) r_pending <= r_pending & ~idx_bit;
                r_cursor[r_idx] <= r_gen;
            end
        end else if (i_cmd.sched_due) begin
            if (!r_stop && !(pend_sel && rem <= r_delay)) begin
                r_pending <= r_pending | idx_bit;
            end
        end else if (i_cmd.single_op) begin
            if (r_op == OP_CLEAR || (r_op == OP_CANCEL && r_gen == cur_sel)) begin
                r_pending <= r_pending & ~idx_bit;
            end
        end else if (i_cmd.due_apply) begin
            r_pending <= r_pending & ~r_mask;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_event) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_out_status <= single_status;
            r_out_found  <= (r_op == OP_NEXT) && r_found;
            r_out_next   <= (r_op == OP_NEXT) ? r_best : '0;
            r_out_mask   <= '0;
            r_out_ev     <= 1'b0;
            r_out_owner  <= '0;
            r_out_gen    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_event) begin
            r_out_status <= ST_OK;
            r_out_found  <= 1'b0;
            r_out_next   <= '0;
            r_out_mask   <= r_mask;
            r_out_ev     <= 1'b1;
            r_out_owner  <= r_idx;
            r_out_gen    <= cur_sel;
            r_out_last   <= o_stat.rest_last;
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.scan_last  = r_idx == 3'(OWNER_SLOTS - 1);
        o_stat.mask_empty = r_mask == '0;
        o_stat.rest_hit   = r_rest[r_idx];
        o_stat.rest_last  = (r_rest & ~idx_bit) == '0;
        o_stat.out_free   = out_free;
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_found            = r_out_found;
    assign o_next_delay_ms    = r_out_next;
    assign o_expired_mask     = r_out_mask;
    assign o_event_valid      = r_out_ev;
    assign o_event_owner      = r_out_owner;
    assign o_event_generation = r_out_gen;
    assign o_last             = r_out_last;

    // Owners reported by take-due are no longer pending
    a_due_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.due_apply |=> (r_pending & r_rest) == '0)
        else $error("due owner still pending after removal");

    // An emitted event names an owner inside its own expired mask
    a_event_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_event |=> o_event_valid && o_expired_mask[o_event_owner])
        else $error("event owner outside expired mask");

    // Best delay stays zero until a pending slot was found
    a_best_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && !r_found && !pend_sel) |=> !r_found && r_best == '0)
        else $error("next-delay scan updated without a pending slot");

endmodule

### rtl/generation_guarded_deadline_timers.sv
// Top level of the generation-guarded deadline timers.
// Depends on ggdt_pkg, ggdt_ctrl and ggdt_dp.
//
// One request is taken at a time; o_ready is high only while the sequencer
// is idle, and a finished result sits in an output register so the next
// request can be taken while it waits. Schedule passes through decode,
// generation check, due-time update and result load before it can take the
// next request; cancel, clear and invalid requests pass through decode, the
// single operation and result load. Next-delay and take-due scan one owner
// slot per cycle through a single subtract-and-compare unit. When owners are
// due, take-due then walks the slots from owner 0 up to the highest due owner,
// one slot per cycle, emitting an event on each due slot and waiting on a due
// slot while the output register is still full. A stalled output also holds
// back the result load of every other request.
module generation_guarded_deadline_timers
    import ggdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [2:0]  i_owner,
    input  logic [63:0] i_generation,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_delay_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_next_delay_ms,
    output logic [7:0]  o_expired_mask,
    output logic        o_event_valid,
    output logic [2:0]  o_event_owner,
    output logic [63:0] o_event_generation,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Request sequencer
    ggdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Timer state and result path
    ggdt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_req_type         (i_req_type),
        .i_owner            (i_owner),
        .i_generation       (i_generation),
        .i_now_ms           (i_now_ms),
        .i_delay_ms         (i_delay_ms),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_found            (o_found),
        .o_next_delay_ms    (o_next_delay_ms),
        .o_expired_mask     (o_expired_mask),
        .o_event_valid      (o_event_valid),
        .o_event_owner      (o_event_owner),
        .o_event_generation (o_event_generation),
        .o_last             (o_last)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for generation_guarded_deadline_timers.
// Depends on ggdt_pkg and the RTL top; a built-in timer predictor checks every result transfer.
`timescale 1ns / 100ps

module testbench
    import ggdt_pkg::*;
;

    localparam int          RANDOM_ITEMS   = 94;
    localparam int          QUIET_LIMIT    = 4000;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          HOLDOFF_AFTER  = 45;
    localparam int          SETTLE_CYCLES  = 40;
    localparam logic [2:0]  REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  REQ_UNUSED_HI  = 3'd7;
    localparam logic [63:0] GEN_MAX        = 64'hFFFF_FFFF_FFFF_FFFF;

    // One timer request as driven on the input channel
    typedef struct {
        logic [2:0]  req;
        logic [2:0]  owner;
        logic [63:0] gen;
        logic [31:0] now;
        logic [31:0] delay;
        bit          drain_first;
    } t_timer_req;

    // One result as seen on the output channel
    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [31:0] next_delay;
        logic [7:0]  expired_mask;
        logic        event_valid;
        logic [2:0]  event_owner;
        logic [63:0] event_gen;
        logic        last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [2:0]  i_owner = '0;
    logic [63:0] i_generation = '0;
    logic [31:0] i_now_ms = '0;
    logic [31:0] i_delay_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_found;
    logic [31:0] o_next_delay_ms;
    logic [7:0]  o_expired_mask;
    logic        o_event_valid;
    logic [2:0]  o_event_owner;
    logic [63:0] o_event_generation;
    logic        o_last;

    generation_guarded_deadline_timers DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_owner            (i_owner),
        .i_generation       (i_generation),
        .i_now_ms           (i_now_ms),
        .i_delay_ms         (i_delay_ms),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_found            (o_found),
        .o_next_delay_ms    (o_next_delay_ms),
        .o_expired_mask     (o_expired_mask),
        .o_event_valid      (o_event_valid),
        .o_event_owner      (o_event_owner),
        .o_event_generation (o_event_generation),
        .o_last             (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_timer_req    request_q[$];
    t_timer_result timer_results_q[$];
    t_timer_req    held_item;

    // Predicted timer state
    logic [7:0]  mdl_pending = '0;
    logic [31:0] mdl_due[0:7];
    logic [63:0] mdl_cursor[0:7];

    // Stimulus-side guess of each cursor, used to aim generations
    logic [63:0] gen_shadow[0:7];
    logic [31:0] stim_now;

    int mismatches = 0;
    int requests_done = 0;
    int results_seen = 0;
    int due_events = 0;
    int stale_seen = 0;
    int invalid_seen = 0;
    int gap_left = 0;
    int burst_left = 4;
    int quiet_cycles = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    logic [31:0] stall_cycle = '0;

    initial begin
        for (int i = 0; i < 8; i++) begin
            mdl_due[i]    = '0;
            mdl_cursor[i] = '0;
            gen_shadow[i] = '0;
        end
    end

    function automatic bit owns_cursor(input int o);
        return o < GENERATION_SLOTS;
    endfunction

    // Wrap-safe due test: signed (now - due) >= 0
    function automatic bit slot_due(input logic [31:0] now, input logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

    function automatic logic [31:0] time_left(input logic [31:0] now, input logic [31:0] due);
        return slot_due(now, due) ? 32'd0 : due - now;
    endfunction

    // Expected results of one accepted request; updates the predicted state
    task automatic predict_timer_request(input t_timer_req rq);
        t_timer_result r;
        logic [7:0]    taken;
        logic [7:0]    obit;
        logic [31:0]   best;
        logic [31:0]   left;
        logic [63:0]   want;
        logic          found;
        int            o;
        r = '{default: 0};
        o = int'(rq.owner);
        obit = 8'd1 << rq.owner;
        if (rq.req == REQ_TAKE_DUE) begin
            taken = '0;
            for (int i = 0; i < OWNER_SLOTS; i++) begin
                if (mdl_pending[i] && slot_due(rq.now, mdl_due[i])) taken[i] = 1'b1;
            end
            mdl_pending &= ~taken;
            if (taken == 8'd0) begin
                r.status = ST_NONE;
                r.last   = 1'b1;
                timer_results_q.push_back(r);
            end else begin
                for (int i = 0; i < 8; i++) begin
                    if (taken[i]) begin
                        r = '{default: 0};
                        r.status       = ST_OK;
                        r.expired_mask = taken;
                        r.event_valid  = 1'b1;
                        r.event_owner  = 3'(i);
                        r.event_gen    = owns_cursor(i) ? mdl_cursor[i] : 64'd0;
                        r.last         = ((taken >> (i + 1)) == 8'd0);
                        timer_results_q.push_back(r);
                        due_events++;
                    end
                end
            end
            return;
        end
        r.last   = 1'b1;
        r.status = ST_INVALID;
        if (rq.req == REQ_NEXT) begin
            found = 1'b0;
            best  = '0;
            for (int i = 0; i < OWNER_SLOTS; i++) begin
                if (mdl_pending[i]) begin
                    left = time_left(rq.now, mdl_due[i]);
                    if (!found || left < best) best = left;
                    found = 1'b1;
                end
            end
            r.found      = found;
            r.next_delay = best;
            r.status     = found ? ST_OK : ST_NONE;
        end else if (rq.req <= REQ_CLEAR && o < OWNER_SLOTS) begin
            if (rq.req == REQ_SCHEDULE) begin
                if (rq.delay > MAX_DELAY_MS) begin
                    r.status = ST_INVALID;
                end else if (!owns_cursor(o) && rq.gen != 64'd0) begin
                    r.status = ST_INVALID;
                end else if (owns_cursor(o) && (rq.gen == 64'd0 || rq.gen < mdl_cursor[o])) begin
                    r.status = ST_STALE;
                end else begin
                    if (owns_cursor(o)) begin
                        // a newer generation discards the old deadline
                        if (rq.gen > mdl_cursor[o]) mdl_pending &= ~obit;
                        mdl_cursor[o] = rq.gen;
                    end
                    // only ever shorten a pending deadline
                    if (!(mdl_pending[o] && time_left(rq.now, mdl_due[o]) <= rq.delay)) begin
                        mdl_due[o]  = rq.now + rq.delay;
                        mdl_pending |= obit;
                    end
                    r.status = ST_OK;
                end
            end else if (rq.req == REQ_CANCEL) begin
                want = owns_cursor(o) ? mdl_cursor[o] : 64'd0;
                if (rq.gen != want) begin
                    r.status = ST_MISMATCH;
                end else begin
                    mdl_pending &= ~obit;
                    r.status = ST_OK;
                end
            end else begin
                mdl_pending &= ~obit;
                r.status = ST_OK;
            end
        end
        if (r.status == ST_STALE) stale_seen++;
        if (r.status == ST_INVALID) invalid_seen++;
        timer_results_q.push_back(r);
    endtask

    function automatic t_timer_req mk(input logic [2:0] req, input logic [2:0] owner,
                                      input logic [63:0] gen, input logic [31:0] now,
                                      input logic [31:0] delay);
        t_timer_req rq;
        rq.req         = req;
        rq.owner       = owner;
        rq.gen         = gen;
        rq.now         = now;
        rq.delay       = delay;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    // Queue a request and follow the cursor it would set
    task automatic queue_request(input t_timer_req rq);
        if (rq.req == REQ_SCHEDULE && rq.owner < GENERATION_SLOTS && rq.delay <= MAX_DELAY_MS &&
            rq.gen != 64'd0 && rq.gen >= gen_shadow[rq.owner]) begin
            gen_shadow[rq.owner] = rq.gen;
        end
        request_q.push_back(rq);
    endtask

    function automatic logic [63:0] pick_generation(input int o);
        int          k;
        logic [63:0] g;
        k = $urandom_range(0, 9);
        if (!owns_cursor(o)) return (k == 9) ? {$urandom, $urandom} : 64'd0;
        g = gen_shadow[o];
        if (k < 6) begin
            if (g == 64'd0) g = 64'd1;
        end else if (k < 8) begin
            if (g != GEN_MAX) g = g + 64'd1;
        end else if (k == 8) begin
            if (g != 64'd0) g = g - 64'd1;
        end else begin
            g = 64'd0;
        end
        return g;
    endfunction

    // Mostly well-formed requests on a moving clock, some noise
    function automatic t_timer_req random_request();
        t_timer_req rq;
        int         k;
        int         d;
        k = $urandom_range(0, 99);
        if (k < 80) stim_now = stim_now + $urandom_range(0, 60);
        else if (k < 95) stim_now = stim_now + $urandom_range(100, 600);
        else stim_now = $urandom;
        rq = mk(REQ_NEXT, 3'($urandom_range(0, 7)), 64'd0, stim_now, 32'd0);
        k = $urandom_range(0, 99);
        if (k < 40) begin
            rq.req   = REQ_SCHEDULE;
            rq.owner = 3'($urandom_range(0, OWNER_SLOTS - 1));
            rq.gen   = pick_generation(int'(rq.owner));
            d = $urandom_range(0, 19);
            if (d == 0) rq.delay = MAX_DELAY_MS;
            else if (d == 1) rq.delay = $urandom | 32'h8000_0000;
            else if (d == 2) rq.delay = $urandom_range(0, 32'h7FFF_FFFF);
            else rq.delay = $urandom_range(0, 400);
        end else if (k < 50) begin
            rq.req   = REQ_CANCEL;
            rq.owner = 3'($urandom_range(0, OWNER_SLOTS - 1));
            if ($urandom_range(0, 9) < 7)
                rq.gen = owns_cursor(int'(rq.owner)) ? gen_shadow[rq.owner] : 64'd0;
            else
                rq.gen = {$urandom, $urandom};
        end else if (k < 58) begin
            rq.req = REQ_CLEAR;
        end else if (k < 70) begin
            rq.req = REQ_NEXT;
        end else if (k < 88) begin
            rq.req = REQ_TAKE_DUE;
        end else begin
            rq.req   = 3'($urandom_range(0, 7));
            rq.gen   = {$urandom, $urandom};
            rq.delay = $urandom;
        end
        return rq;
    endfunction

    // Driver: bursts of transfers with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_timer_request(held_item);
                requests_done++;
            end
            if ((i_valid && o_ready) || !i_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].drain_first && timer_results_q.size() != 0)) begin
                    held_item = request_q.pop_front();
                    i_valid      <= 1'b1;
                    i_req_type   <= held_item.req;
                    i_owner      <= held_item.owner;
                    i_generation <= held_item.gen;
                    i_now_ms     <= held_item.now;
                    i_delay_ms   <= held_item.delay;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off, otherwise a rotating stall pattern
    always @(posedge i_clk) begin
        stall_cycle = stall_cycle + 32'd1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            i_ready <= 1'b0;
        end else begin
            case (stall_cycle[8:7])
                2'd0: begin
                    i_ready <= 1'b1;
                end
                2'd1: begin
                    i_ready <= 1'($urandom_range(0, 1));
                end
                2'd2: begin
                    i_ready <= (stall_cycle[2:0] != 3'd5);
                end
                default: begin
                    i_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_timer_result r;
        if (i_rst_n && o_valid && i_ready) begin
            if (timer_results_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d owner %0d",
                         $time, o_status, o_event_owner);
                mismatches++;
            end else begin
                r = timer_results_q.pop_front();
                check_field("status", 64'(r.status), 64'(o_status));
                check_field("found", 64'(r.found), 64'(o_found));
                check_field("next_delay_ms", 64'(r.next_delay), 64'(o_next_delay_ms));
                check_field("expired_mask", 64'(r.expired_mask), 64'(o_expired_mask));
                check_field("event_valid", 64'(r.event_valid), 64'(o_event_valid));
                check_field("event_owner", 64'(r.event_owner), 64'(o_event_owner));
                check_field("event_generation", r.event_gen, o_event_generation);
                check_field("last", 64'(r.last), 64'(o_last));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, timer_results_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_timer_req rq;
        // Directed: empty queries, shorten/keep, stale and newer generations,
        // bad owners and delays, wrap of the clock, unknown requests, multi-owner take
        queue_request(mk(REQ_NEXT, 3'd0, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_TAKE_DUE, 3'd0, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd0, 32'd0, 32'd100));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd1, 32'd0, 32'd100));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd1, 32'd10, 32'd200));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd1, 32'd10, 32'd50));
        queue_request(mk(REQ_SCHEDULE, 3'd4, 64'd5, 32'd10, 32'd10));
        queue_request(mk(REQ_SCHEDULE, 3'd4, 64'd0, 32'hFFFF_FFF0, MAX_DELAY_MS));
        queue_request(mk(REQ_SCHEDULE, 3'd1, 64'd1, 32'd10, 32'h8000_0000));
        queue_request(mk(REQ_SCHEDULE, 3'd5, 64'd0, 32'd10, 32'd10));
        queue_request(mk(REQ_CANCEL, 3'd7, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_CANCEL, 3'd0, 64'd2, 32'd0, 32'd0));
        queue_request(mk(REQ_SCHEDULE, 3'd2, 64'd3, 32'd20, 32'd0));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd2, 32'd20, 32'd300));
        queue_request(mk(REQ_SCHEDULE, 3'd0, 64'd1, 32'd20, 32'd5));
        queue_request(mk(REQ_NEXT, 3'd0, 64'd0, 32'd20, 32'd0));
        queue_request(mk(REQ_CANCEL, 3'd0, 64'd2, 32'd25, 32'd0));
        queue_request(mk(REQ_CLEAR, 3'd6, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_CLEAR, 3'd4, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_SCHEDULE, 3'd1, 64'd7, 32'd30, 32'd40));
        queue_request(mk(REQ_SCHEDULE, 3'd3, GEN_MAX, 32'd30, 32'd5));
        queue_request(mk(REQ_SCHEDULE, 3'd4, 64'd0, 32'd30, 32'd20));
        queue_request(mk(REQ_UNUSED_LO, 3'd0, 64'd0, 32'd0, 32'd0));
        queue_request(mk(REQ_UNUSED_HI, 3'd7, GEN_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_request(mk(REQ_NEXT, 3'd0, 64'd0, 32'd32, 32'd0));
        queue_request(mk(REQ_TAKE_DUE, 3'd0, 64'd0, 32'd60, 32'd0));
        queue_request(mk(REQ_TAKE_DUE, 3'd0, 64'd0, 32'd100, 32'd0));

        // Random part starts just short of the clock wrap
        stim_now = 32'hFFFF_F000;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            rq = random_request();
            rq.drain_first = (k == 0 || k == RANDOM_ITEMS / 2);
            queue_request(rq);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_valid) @(posedge i_clk);
        while (timer_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d results, incl. %0d due events,",
                 requests_done, results_seen, due_events);
        $display("%0d stale and %0d invalid responses, with a %0d-cycle output hold-off.",
                 stale_seen, invalid_seen, HOLDOFF_CYCLES);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
